@@ src/rwts_pkg.sv @@
package rwts_pkg;

  // request codes
  localparam logic [2:0] REQ_POLL   = 3'd0;
  localparam logic [2:0] REQ_INIT   = 3'd1;
  localparam logic [2:0] REQ_RESUME = 3'd2;
  localparam logic [2:0] REQ_STOP   = 3'd3;
  localparam logic [2:0] REQ_FAULT  = 3'd4;

  // test phase codes, shown on state_code
  localparam logic [3:0] PH_INIT     = 4'd0;
  localparam logic [3:0] PH_IDLE     = 4'd1;
  localparam logic [3:0] PH_RUNNING  = 4'd2;
  localparam logic [3:0] PH_STEP_ON  = 4'd3;
  localparam logic [3:0] PH_DEAD     = 4'd4;
  localparam logic [3:0] PH_CHANGE   = 4'd5;
  localparam logic [3:0] PH_MEASURE  = 4'd6;
  localparam logic [3:0] PH_FINISHED = 4'd7;
  localparam logic [3:0] PH_ERROR    = 4'd8;

  // configuration register indexes
  localparam logic [2:0] CFG_STEP_MS     = 3'd0;
  localparam logic [2:0] CFG_PAUSE_MS    = 3'd1;
  localparam logic [2:0] CFG_MEASURE_INT = 3'd2;
  localparam logic [2:0] CFG_TARGET      = 3'd3;
  localparam logic [2:0] CFG_SAVE_INT    = 3'd4;

  localparam logic [15:0] RST_STEP_MS     = 16'd500;
  localparam logic [15:0] RST_PAUSE_MS    = 16'd1000;
  localparam logic [31:0] RST_MEASURE_INT = 32'd1000;
  localparam logic [31:0] RST_TARGET      = 32'd100000;
  localparam logic [31:0] RST_SAVE_INT    = 32'd100;

  localparam logic [31:0] DEF_MEASURE = 32'd1000;
  localparam logic [31:0] DEF_TARGET  = 32'd100000;

  localparam logic signed [3:0] ACT_NONE = -4'sd1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] now_ms;
    logic [31:0] start_count;
    logic        start_direction;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        relay_mask;
    logic              direction;
    logic [3:0]        state_code;
    logic signed [3:0] active_channel;
    logic [31:0]       cycle_count;
    logic              save_pulse;
  } status_t;

endpackage

@@ src/rwts_if.sv @@
interface rwts_cmd_if;
  logic            valid;
  logic            ready;
  rwts_pkg::cmd_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface rwts_status_if;
  logic              valid;
  logic              ready;
  rwts_pkg::status_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

@@ src/relay_wave_test_sequencer.sv @@
// a command is registered on acceptance, executed in the exec state, and its status
// loaded in the emit state; an init or a direction change may first pass through the
// check state and a 32-step remainder pass (init checking the measure interval,
// direction change), and a direction change with saving on can run two passes
// throughput: one transaction at a time, the next taken in the cycle after the status
// loads; the load waits while status stalls. reset: synchronous rst restores defaults
module relay_wave_test_sequencer #(
  parameter int CHANNELS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  rwts_cmd_if.sink            cmd,
  rwts_status_if.source       status
);

  localparam int PosW = $clog2(CHANNELS + 1);

  localparam logic [2:0] SQ_IDLE   = 3'd0;
  localparam logic [2:0] SQ_EXEC   = 3'd1;
  localparam logic [2:0] SQ_CHECK  = 3'd2;
  localparam logic [2:0] SQ_DIV    = 3'd3;
  localparam logic [2:0] SQ_DIVEND = 3'd4;
  localparam logic [2:0] SQ_EMIT   = 3'd5;

  logic [2:0]          seq;
  rwts_pkg::cmd_t      item;
  logic [15:0]         step_ms;
  logic [15:0]         pause_ms;
  logic [31:0]         measure_int;
  logic [31:0]         target;
  logic [31:0]         save_int;

  logic [3:0]          phase;
  logic [CHANNELS-1:0] relay_bits;
  logic [PosW-1:0]     step_position;
  logic [31:0]         step_timestamp;
  logic [31:0]         cycles_done;
  logic                dir_bit;
  logic                idle_off_done;
  logic                finish_off_done;
  logic                save_flag;

  logic [31:0]         div_rem;
  logic [31:0]         div_dvd;
  logic [31:0]         div_dvs;
  logic [4:0]          div_cnt;
  logic                div_save;

  logic                status_valid;
  rwts_pkg::status_t   status_q;

  logic [31:0]           eff_measure;
  logic [31:0]           eff_target;
  logic [31:0]           elapsed;
  logic [15:0]           wait_ms;
  logic                  timer_hit;
  logic [CHANNELS-1:0]   relay_next;
  logic [32:0]           rem_shift;
  logic [32:0]           rem_sub;
  logic [31:0]           rem_next;
  logic                  past_target;
  logic [4:0]            pos_ext;
  logic signed [3:0]     active;
  logic [CHANNELS+7:0]   relay_wide;

  assign eff_measure = (measure_int != '0) ? measure_int : rwts_pkg::DEF_MEASURE;
  assign eff_target  = (target != '0) ? target : rwts_pkg::DEF_TARGET;
  assign past_target = cycles_done >= eff_target;

  // one timer compare serves both step_on and the all-off pause
  assign elapsed   = item.now_ms - step_timestamp;
  assign wait_ms   = (phase == rwts_pkg::PH_STEP_ON) ? step_ms : pause_ms;
  assign timer_hit = elapsed >= {16'd0, wait_ms};

  // drop the previous channel, raise the current one
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      relay_next[i] = relay_bits[i];
      if (PosW'(i + 1) == step_position) relay_next[i] = 1'b0;
      if (PosW'(i) == step_position) relay_next[i] = 1'b1;
    end
  end

  // restoring remainder step
  assign rem_shift = {div_rem, div_dvd[31]};
  assign rem_sub   = rem_shift - {1'b0, div_dvs};
  assign rem_next  = rem_sub[32] ? rem_shift[31:0] : rem_sub[31:0];

  assign pos_ext = 5'(step_position);
  always_comb begin
    active = rwts_pkg::ACT_NONE;
    if (phase == rwts_pkg::PH_STEP_ON && step_position != '0 &&
        step_position <= PosW'(CHANNELS)) begin
      active = 4'(pos_ext - 5'd1);
    end
  end

  assign relay_wide = {8'd0, relay_bits};

  assign cmd.ready      = (seq == SQ_IDLE);
  assign status.valid   = status_valid;
  assign status.payload = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq             <= SQ_IDLE;
      step_ms         <= rwts_pkg::RST_STEP_MS;
      pause_ms        <= rwts_pkg::RST_PAUSE_MS;
      measure_int     <= rwts_pkg::RST_MEASURE_INT;
      target          <= rwts_pkg::RST_TARGET;
      save_int        <= rwts_pkg::RST_SAVE_INT;
      phase           <= rwts_pkg::PH_INIT;
      relay_bits      <= '0;
      step_position   <= '0;
      step_timestamp  <= '0;
      cycles_done     <= '0;
      dir_bit         <= 1'b0;
      idle_off_done   <= 1'b0;
      finish_off_done <= 1'b0;
      save_flag       <= 1'b0;
      div_cnt         <= '0;
      div_save        <= 1'b0;
      status_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rwts_pkg::CFG_STEP_MS:     step_ms     <= cfg_data[15:0];
          rwts_pkg::CFG_PAUSE_MS:    pause_ms    <= cfg_data[15:0];
          rwts_pkg::CFG_MEASURE_INT: measure_int <= cfg_data;
          rwts_pkg::CFG_TARGET:      target      <= cfg_data;
          rwts_pkg::CFG_SAVE_INT:    save_int    <= cfg_data;
          default: ;
        endcase
      end

      if (status_valid && status.ready && seq != SQ_EMIT) status_valid <= 1'b0;

      unique case (seq)
        SQ_IDLE: begin
          if (cmd.valid) begin
            item      <= cmd.payload;
            save_flag <= 1'b0;
            seq       <= SQ_EXEC;
          end
        end
        SQ_EXEC: begin
          seq <= SQ_EMIT;
          unique case (item.req_type)
            rwts_pkg::REQ_INIT: begin
              cycles_done <= item.start_count;
              dir_bit     <= item.start_direction;
              seq         <= SQ_CHECK;
            end
            rwts_pkg::REQ_RESUME: phase <= rwts_pkg::PH_RUNNING;
            rwts_pkg::REQ_STOP:   phase <= rwts_pkg::PH_IDLE;
            rwts_pkg::REQ_FAULT:  phase <= rwts_pkg::PH_ERROR;
            default: begin
              // poll, and the unused codes with it
              unique case (phase)
                rwts_pkg::PH_IDLE: begin
                  if (!idle_off_done) begin
                    relay_bits    <= '0;
                    idle_off_done <= 1'b1;
                  end
                end
                rwts_pkg::PH_FINISHED: begin
                  if (!finish_off_done) begin
                    relay_bits      <= '0;
                    finish_off_done <= 1'b1;
                  end
                end
                rwts_pkg::PH_RUNNING: begin
                  step_position   <= '0;
                  step_timestamp  <= item.now_ms;
                  idle_off_done   <= 1'b0;
                  finish_off_done <= 1'b0;
                  phase           <= rwts_pkg::PH_STEP_ON;
                end
                rwts_pkg::PH_STEP_ON: begin
                  if (timer_hit) begin
                    relay_bits     <= relay_next;
                    step_timestamp <= item.now_ms;
                    if (step_position < PosW'(CHANNELS)) begin
                      step_position <= step_position + PosW'(1);
                    end else begin
                      phase <= rwts_pkg::PH_DEAD;
                    end
                  end
                end
                rwts_pkg::PH_DEAD: begin
                  if (timer_hit) phase <= rwts_pkg::PH_CHANGE;
                end
                rwts_pkg::PH_CHANGE: begin
                  cycles_done <= cycles_done + 32'd1;
                  dir_bit     <= ~dir_bit;
                  if (save_int != '0) begin
                    div_dvd  <= cycles_done + 32'd1;
                    div_dvs  <= save_int;
                    div_rem  <= '0;
                    div_cnt  <= '0;
                    div_save <= 1'b1;
                    seq      <= SQ_DIV;
                  end else begin
                    seq <= SQ_CHECK;
                  end
                end
                rwts_pkg::PH_ERROR: relay_bits <= '0;
                default: ;
              endcase
            end
          endcase
        end
        SQ_CHECK: begin
          if (past_target) begin
            phase <= rwts_pkg::PH_FINISHED;
            seq   <= SQ_EMIT;
          end else if (item.req_type == rwts_pkg::REQ_INIT && cycles_done == '0) begin
            phase <= rwts_pkg::PH_RUNNING;
            seq   <= SQ_EMIT;
          end else begin
            div_dvd  <= cycles_done;
            div_dvs  <= eff_measure;
            div_rem  <= '0;
            div_cnt  <= '0;
            div_save <= 1'b0;
            seq      <= SQ_DIV;
          end
        end
        SQ_DIV: begin
          div_rem <= rem_next;
          div_dvd <= {div_dvd[30:0], 1'b0};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) seq <= SQ_DIVEND;
        end
        SQ_DIVEND: begin
          if (div_save) begin
            save_flag <= (div_rem == '0);
            seq       <= SQ_CHECK;
          end else begin
            phase <= (div_rem == '0) ? rwts_pkg::PH_MEASURE : rwts_pkg::PH_RUNNING;
            seq   <= SQ_EMIT;
          end
        end
        SQ_EMIT: begin
          if (!status_valid || status.ready) begin
            status_q.relay_mask     <= relay_wide[7:0];
            status_q.direction      <= dir_bit;
            status_q.state_code     <= phase;
            status_q.active_channel <= active;
            status_q.cycle_count    <= cycles_done;
            status_q.save_pulse     <= save_flag;
            status_valid            <= 1'b1;
            seq                     <= SQ_IDLE;
          end
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

endmodule

@@ src/rwts_checker.sv @@
module rwts_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              status_valid,
  input logic              status_ready,
  input rwts_pkg::status_t status_payload
);

  // a stalled status transaction keeps its contents
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    status_valid && !status_ready |=> status_valid && $stable(status_payload))
    else $error("status changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  a_channel_only_in_step: assert property (@(posedge clk) disable iff (rst)
    status_valid |-> (status_payload.active_channel == rwts_pkg::ACT_NONE ||
                      status_payload.state_code == rwts_pkg::PH_STEP_ON))
    else $error("active channel outside step phase");

  // a save request only comes out of a direction change
  a_save_after_change: assert property (@(posedge clk) disable iff (rst)
    status_valid && status_payload.save_pulse |->
      (status_payload.state_code == rwts_pkg::PH_RUNNING ||
       status_payload.state_code == rwts_pkg::PH_MEASURE ||
       status_payload.state_code == rwts_pkg::PH_FINISHED))
    else $error("save pulse in unexpected phase");

  a_reset_clears_status: assert property (@(posedge clk) rst |=> !status_valid)
    else $error("status valid after reset");

endmodule

bind relay_wave_test_sequencer rwts_checker u_rwts_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .status_valid   (status.valid),
  .status_ready   (status.ready),
  .status_payload (status.payload)
);
